// ----- design/hst_pkg.sv -----
// Shared types and constants for the host status table.
package hst_pkg;

    localparam int TableDepth = 64;
    localparam int IdxW = $clog2(TableDepth);
    localparam int CntW = $clog2(TableDepth + 1);

    localparam logic [1:0] OP_OBSERVE = 2'd0;
    localparam logic [1:0] OP_PROBE   = 2'd1;
    localparam logic [1:0] OP_LIST    = 2'd2;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    localparam logic [2:0] ST_UPDATED  = 3'd0;
    localparam logic [2:0] ST_ALIVE    = 3'd1;
    localparam logic [2:0] ST_OUTSIDE  = 3'd2;
    localparam logic [2:0] ST_LIMIT    = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_NOTFOUND = 3'd5;
    localparam logic [2:0] ST_NONE     = 3'd6;

    localparam logic [1:0] REG_BASE  = 2'd0;
    localparam logic [1:0] REG_HOSTS = 2'd1;
    localparam logic [1:0] REG_LIMIT = 2'd2;

    localparam int FL_ALIVE = 0;
    localparam int FL_DEAD  = 1;
    localparam int FL_DISC  = 2;
    localparam int FL_DONE  = 3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the input transaction
        logic clr_scan;  // restart the slot walk
        logic rd;        // issue a store read at the scan slot
        logic step;      // advance the scan slot
        logic hit_cap;   // record current read as the match
        logic wr_obs;    // write observe update
        logic wr_prb;    // write probe update
        logic emit;      // load the output register
        logic [2:0] emit_status;
        logic emit_zero; // zero the index fields
        logic emit_last;
    } hst_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] op;
        logic in_range;
        logic scan_end;   // scan slot reached entry count
        logic rd_match;   // read host equals target
        logic rd_pending; // read entry is neither alive nor done
        logic found;
        logic found_alive;
        logic at_limit;
        logic full;
        logic out_busy;
    } hst_stat_t;

endpackage

// ----- design/host_status_table.sv -----
// Host status table: a table of up to 64 subnet hosts with status flags and best
// connect times. One transaction is handled at a time. An observe, probe or listing
// walks the table through the single store port, reading the occupied entries in
// slot order and waiting on any output stall; a lookup stops early at its match.
// An observe outside the subnet gives its result without a walk. A listing holds
// each pending entry back until the next one is found, so its final result carries
// last. Unused operation code 3 is dropped without a result. Stores hold no reset
// value; only entries below the entry count are read.
module host_status_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [31:0] address,
    input  logic [1:0]  source,
    input  logic        probe_alive,
    input  logic        probe_dead,
    input  logic [15:0] connect_time,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [5:0]  entry_index,
    output logic [31:0] host_index,
    output logic        last
);
    hst_pkg::hst_cmd_t  cmd;
    hst_pkg::hst_stat_t stat;

    assign pready = 1'b1;

    hst_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .stat(stat), .cmd(cmd));

    hst_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .operation(operation),
        .address(address), .source(source), .probe_alive(probe_alive),
        .probe_dead(probe_dead), .connect_time(connect_time), .cmd(cmd),
        .stat(stat), .out_valid(out_valid), .out_stall(out_stall), .status(status),
        .entry_index(entry_index), .host_index(host_index), .last(last));
endmodule

// ----- design/hst_ram.sv -----
// Generic single-port RAM with registered read.
module hst_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    // Write, with a registered read that returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ----- design/hst_datapath.sv -----
// Datapath: configuration registers, table stores, counters and output register.
module hst_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    input  logic [1:0]            operation,
    input  logic [31:0]           address,
    input  logic [1:0]            source,
    input  logic                  probe_alive,
    input  logic                  probe_dead,
    input  logic [15:0]           connect_time,
    input  hst_pkg::hst_cmd_t     cmd,
    output hst_pkg::hst_stat_t    stat,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [2:0]            status,
    output logic [5:0]            entry_index,
    output logic [31:0]           host_index,
    output logic                  last
);
    localparam int IW = hst_pkg::IdxW;
    localparam int CW = hst_pkg::CntW;

    logic [31:0] base_reg, hosts_reg;
    logic [6:0]  limit_reg;
    logic [1:0]  op_reg;
    logic [31:0] tgt_reg;
    logic [1:0]  src_reg;
    logic        pal_reg, pde_reg;
    logic [15:0] ms_reg;
    logic        range_reg;
    logic [CW-1:0] scan_reg, ecount_reg;
    logic [6:0]  acount_reg;
    logic [IW-1:0] rslot_reg, hit_reg;
    logic        found_reg;
    logic [7:0]  hflag_reg;
    logic [15:0] hlat_reg;
    logic [31:0] hhost_reg;
    logic        ovalid_reg;
    logic [2:0]  ost_reg;
    logic [5:0]  oidx_reg;
    logic [31:0] ohost_reg;
    logic        olast_reg;

    logic [31:0] rd_host;
    logic [7:0]  rd_flag;
    logic [15:0] rd_lat;
    logic        we;
    logic [IW-1:0] ram_addr, new_slot;
    logic [31:0] wr_host;
    logic [7:0]  wr_flag, base_flag;
    logic [15:0] wr_lat, base_lat;
    logic [32:0] top;
    logic        cfg_wr;

    // Configuration port.
    assign cfg_wr = psel && penable && pwrite;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            hosts_reg <= 32'd255;
            limit_reg <= 7'd64;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                hst_pkg::REG_BASE:  base_reg  <= pwdata;
                hst_pkg::REG_HOSTS: hosts_reg <= pwdata;
                hst_pkg::REG_LIMIT: limit_reg <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            hst_pkg::REG_BASE:  prdata = base_reg;
            hst_pkg::REG_HOSTS: prdata = hosts_reg;
            hst_pkg::REG_LIMIT: prdata = {25'd0, limit_reg};
            default:            prdata = '0;
        endcase
    end

    // Capture the input transaction and its subnet check.
    assign top = {1'b0, base_reg} + {1'b0, hosts_reg};
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= operation;
            tgt_reg   <= address - base_reg;
            src_reg   <= source;
            pal_reg   <= probe_alive;
            pde_reg   <= probe_dead;
            ms_reg    <= connect_time;
            range_reg <= (address > base_reg) && ({1'b0, address} < top);
        end
    end

    // Scan slot counter and read-slot tracking.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg  <= '0;
            rslot_reg <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_scan)
            begin
                scan_reg  <= '0;
                found_reg <= 1'b0;
            end
            else if (cmd.step)
            begin
                scan_reg <= scan_reg + 1'b1;
            end
            if (cmd.rd)
            begin
                rslot_reg <= scan_reg[IW-1:0];
            end
            if (cmd.hit_cap)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    // Remember the matching entry, or the pending entry held back while listing.
    always_ff @(posedge clk)
    begin
        if (cmd.hit_cap)
        begin
            hit_reg   <= rslot_reg;
            hflag_reg <= rd_flag;
            hlat_reg  <= rd_lat;
            hhost_reg <= rd_host;
        end
    end

    // Store write data.
    assign new_slot = ecount_reg[IW-1:0];
    always_comb
    begin
        base_flag = found_reg ? hflag_reg : 8'd0;
        base_lat  = found_reg ? hlat_reg : 16'd0;
        wr_flag   = base_flag;
        wr_lat    = base_lat;
        wr_host   = tgt_reg;
        if (cmd.wr_obs || pal_reg)
        begin
            wr_flag[hst_pkg::FL_DEAD]  = 1'b0;
            wr_flag[hst_pkg::FL_ALIVE] = 1'b1;
            wr_flag[hst_pkg::FL_DISC]  = 1'b1;
            wr_flag[hst_pkg::FL_DONE]  = 1'b1;
            wr_flag[4 + 32'(src_reg)]  = 1'b1;
            if (cmd.wr_prb && ms_reg != 16'd0 && (base_lat == 16'd0 || ms_reg < base_lat))
            begin
                wr_lat = ms_reg;
            end
        end
        else if (pde_reg && !base_flag[hst_pkg::FL_ALIVE])
        begin
            wr_flag[hst_pkg::FL_DEAD] = 1'b1;
            wr_flag[hst_pkg::FL_DONE] = 1'b1;
        end
    end

    assign we = cmd.wr_obs || cmd.wr_prb;
    always_comb
    begin
        if (we)
        begin
            ram_addr = found_reg ? hit_reg : new_slot;
        end
        else
        begin
            ram_addr = scan_reg[IW-1:0];
        end
    end

    hst_ram #(.Width(32), .Depth(hst_pkg::TableDepth)) u_host (
        .clk(clk), .we(we), .addr(ram_addr), .wdata(wr_host), .rdata(rd_host));
    hst_ram #(.Width(8), .Depth(hst_pkg::TableDepth)) u_flag (
        .clk(clk), .we(we), .addr(ram_addr), .wdata(wr_flag), .rdata(rd_flag));
    hst_ram #(.Width(16), .Depth(hst_pkg::TableDepth)) u_lat (
        .clk(clk), .we(we), .addr(ram_addr), .wdata(wr_lat), .rdata(rd_lat));

    // Entry and alive counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ecount_reg <= '0;
            acount_reg <= '0;
        end
        else if (we)
        begin
            if (cmd.wr_obs && !found_reg)
            begin
                ecount_reg <= ecount_reg + 1'b1;
            end
            if (wr_flag[hst_pkg::FL_ALIVE] && !base_flag[hst_pkg::FL_ALIVE]
                && acount_reg != 7'd127)
            begin
                acount_reg <= acount_reg + 1'b1;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            ost_reg   <= cmd.emit_status;
            olast_reg <= cmd.emit_last;
            if (cmd.emit_zero)
            begin
                oidx_reg  <= '0;
                ohost_reg <= '0;
            end
            else if (op_reg == hst_pkg::OP_LIST)
            begin
                oidx_reg  <= 6'(hit_reg);
                ohost_reg <= hhost_reg;
            end
            else
            begin
                oidx_reg  <= 6'(found_reg ? hit_reg : new_slot);
                ohost_reg <= tgt_reg;
            end
        end
    end

    assign out_valid   = ovalid_reg;
    assign status      = ost_reg;
    assign entry_index = oidx_reg;
    assign host_index  = ohost_reg;
    assign last        = olast_reg;

    // Status toward the controller.
    assign stat.op          = op_reg;
    assign stat.in_range    = range_reg;
    assign stat.scan_end    = (scan_reg >= ecount_reg);
    assign stat.rd_match    = (rd_host == tgt_reg);
    assign stat.rd_pending  = !rd_flag[hst_pkg::FL_ALIVE] && !rd_flag[hst_pkg::FL_DONE];
    assign stat.found       = found_reg;
    assign stat.found_alive = hflag_reg[hst_pkg::FL_ALIVE];
    assign stat.at_limit    = ({1'b0, acount_reg} >= {1'b0, limit_reg});
    assign stat.full        = (ecount_reg >= CW'(hst_pkg::TableDepth));
    assign stat.out_busy    = ovalid_reg && out_stall;
endmodule

// ----- design/hst_ctrl.sv -----
// Controller: sequences lookup, update and listing over the table.
module hst_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  hst_pkg::hst_stat_t stat,
    output hst_pkg::hst_cmd_t  cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_DISPATCH, S_SCAN, S_CHECK, S_DECIDE, S_LIST_CHECK, S_NONE
    } state_t;

    state_t state_reg, state_next;
    logic   any_reg, any_next;

    assign in_stall = (state_reg != S_IDLE);

    // Next-state and command logic.
    always_comb
    begin
        state_next = state_reg;
        any_next   = any_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load     = 1'b1;
                    cmd.clr_scan = 1'b1;
                    state_next   = S_DISPATCH;
                    any_next     = 1'b0;
                end
            end
            S_DISPATCH:
            begin
                if (stat.op == hst_pkg::OP_OBSERVE && !stat.in_range)
                begin
                    if (!stat.out_busy)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = hst_pkg::ST_OUTSIDE;
                        cmd.emit_zero   = 1'b1;
                        cmd.emit_last   = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else if (stat.op == hst_pkg::OP_UNUSED)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_end)
                begin
                    state_next = (stat.op == hst_pkg::OP_LIST) ? S_NONE : S_DECIDE;
                end
                else if (!stat.out_busy)
                begin
                    cmd.rd     = 1'b1;
                    cmd.step   = 1'b1;
                    state_next = (stat.op == hst_pkg::OP_LIST) ? S_LIST_CHECK : S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.rd_match)
                begin
                    cmd.hit_cap = 1'b1;
                    state_next  = S_DECIDE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_LIST_CHECK:
            begin
                // A pending entry is held back until the next one is found so the final one can carry last.
                if (stat.rd_pending)
                begin
                    cmd.hit_cap = 1'b1;
                    any_next    = 1'b1;
                    if (any_reg)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = hst_pkg::ST_UPDATED;
                        cmd.emit_last   = 1'b0;
                    end
                end
                state_next = S_SCAN;
            end
            S_NONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    if (any_reg)
                    begin
                        cmd.emit_status = hst_pkg::ST_UPDATED;
                    end
                    else
                    begin
                        cmd.emit_status = hst_pkg::ST_NONE;
                        cmd.emit_zero   = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_DECIDE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                    if (stat.op == hst_pkg::OP_PROBE)
                    begin
                        if (stat.found)
                        begin
                            cmd.wr_prb      = 1'b1;
                            cmd.emit_status = hst_pkg::ST_UPDATED;
                        end
                        else
                        begin
                            cmd.emit_status = hst_pkg::ST_NOTFOUND;
                            cmd.emit_zero   = 1'b1;
                        end
                    end
                    else if (stat.found && stat.found_alive)
                    begin
                        cmd.emit_status = hst_pkg::ST_ALIVE;
                    end
                    else if (stat.at_limit)
                    begin
                        cmd.emit_status = hst_pkg::ST_LIMIT;
                        cmd.emit_zero   = 1'b1;
                    end
                    else if (!stat.found && stat.full)
                    begin
                        cmd.emit_status = hst_pkg::ST_FULL;
                        cmd.emit_zero   = 1'b1;
                    end
                    else
                    begin
                        cmd.wr_obs      = 1'b1;
                        cmd.emit_status = hst_pkg::ST_UPDATED;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            any_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            any_reg   <= any_next;
        end
    end
endmodule

// ----- design/hst_checker.sv -----
// Port-level checker for the host status table, bound to the top level.
module hst_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  status,
    input logic [5:0]  entry_index,
    input logic [31:0] host_index,
    input logic        last
);
    // A stalled result holds its status and host index.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(host_index))
        else $error("stalled result changed");

    // Results with no entry carry zero indices.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == hst_pkg::ST_OUTSIDE || status == hst_pkg::ST_NOTFOUND
        || status == hst_pkg::ST_NONE || status == hst_pkg::ST_LIMIT
        || status == hst_pkg::ST_FULL) |-> entry_index == 6'd0 && host_index == 32'd0)
        else $error("unused fields not zero");

    // Every single-result status is final.
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != hst_pkg::ST_UPDATED |-> last)
        else $error("single result without last");

    // Accepting a transaction makes the block busy next cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted back to back");
endmodule

bind host_status_table hst_checker u_hst_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .entry_index(entry_index), .host_index(host_index), .last(last));

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the host status table.
`timescale 1ns / 1ps

module tb;

    localparam int StallMax = 4;
    localparam int QuietLimit = 4000;

    // One input transaction.
    typedef struct {
        logic [1:0]  op;
        logic [31:0] addr;
        logic [1:0]  src;
        logic        p_alive;
        logic        p_dead;
        logic [15:0] ms;
    } host_req_t;

    // One result transaction.
    typedef struct {
        logic [2:0]  st;
        logic [5:0]  slot;
        logic [31:0] host;
        logic        fin;
    } host_rsp_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  operation;
    logic [31:0] address;
    logic [1:0]  source;
    logic        probe_alive;
    logic        probe_dead;
    logic [15:0] connect_time;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic [5:0]  entry_index;
    logic [31:0] host_index;
    logic        last;

    host_status_table DUT (.*);

    // Shadow copy of the table and its settings.
    logic [31:0] sub_base;
    logic [31:0] net_hosts;
    logic [6:0]  live_cap;
    logic [31:0] hosts_q [hst_pkg::TableDepth];
    logic [7:0]  flags_q [hst_pkg::TableDepth];
    logic [15:0] ms_q    [hst_pkg::TableDepth];
    int          n_entries;
    int          n_alive;

    host_req_t pending_reqs[$];
    host_rsp_t awaited_rsps[$];
    int        n_errors;
    int        quiet_cycles;
    int        in_gap;
    int        out_gap;
    bit        in_fire;
    bit        out_fire;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    function automatic void push_rsp(input logic [2:0] st, input int slot,
                                     input logic [31:0] host, input logic fin);
        host_rsp_t r;
        r.st = st;
        r.slot = slot[5:0];
        r.host = host;
        r.fin = fin;
        awaited_rsps.push_back(r);
    endfunction

    function automatic int find_host(input logic [31:0] host);
        for (int i = 0; i < n_entries; i++)
            if (hosts_q[i] == host)
                return i;
        return -1;
    endfunction

    function automatic void mark_alive(input int slot, input logic [1:0] src,
                                       input logic [15:0] ms);
        if (!flags_q[slot][hst_pkg::FL_ALIVE])
            n_alive++;
        flags_q[slot][hst_pkg::FL_DEAD] = 1'b0;
        flags_q[slot][hst_pkg::FL_ALIVE] = 1'b1;
        flags_q[slot][hst_pkg::FL_DISC] = 1'b1;
        flags_q[slot][hst_pkg::FL_DONE] = 1'b1;
        flags_q[slot][4 + src] = 1'b1;
        if (ms != 0 && (ms_q[slot] == 0 || ms < ms_q[slot]))
            ms_q[slot] = ms;
    endfunction

    // Predict the results of one accepted transaction.
    function automatic void predict_table(input host_req_t q);
        logic [32:0] top;
        logic [31:0] host;
        int slot;
        int n;
        top = {1'b0, sub_base} + {1'b0, net_hosts};
        host = q.addr - sub_base;
        case (q.op)
            hst_pkg::OP_OBSERVE:
            begin
                slot = find_host(host);
                if (q.addr <= sub_base || {1'b0, q.addr} >= top)
                    push_rsp(hst_pkg::ST_OUTSIDE, 0, 32'd0, 1'b1);
                else if (slot >= 0 && flags_q[slot][hst_pkg::FL_ALIVE])
                    push_rsp(hst_pkg::ST_ALIVE, slot, host, 1'b1);
                else if (n_alive >= live_cap)
                    push_rsp(hst_pkg::ST_LIMIT, 0, 32'd0, 1'b1);
                else if (slot < 0 && n_entries >= hst_pkg::TableDepth)
                    push_rsp(hst_pkg::ST_FULL, 0, 32'd0, 1'b1);
                else
                begin
                    if (slot < 0)
                    begin
                        slot = n_entries;
                        hosts_q[slot] = host;
                        flags_q[slot] = '0;
                        ms_q[slot] = '0;
                        n_entries++;
                    end
                    mark_alive(slot, q.src, 16'd0);
                    push_rsp(hst_pkg::ST_UPDATED, slot, host, 1'b1);
                end
            end
            hst_pkg::OP_PROBE:
            begin
                slot = find_host(host);
                if (slot < 0)
                    push_rsp(hst_pkg::ST_NOTFOUND, 0, 32'd0, 1'b1);
                else
                begin
                    if (q.p_alive)
                        mark_alive(slot, q.src, q.ms);
                    else if (q.p_dead && !flags_q[slot][hst_pkg::FL_ALIVE])
                    begin
                        flags_q[slot][hst_pkg::FL_DEAD] = 1'b1;
                        flags_q[slot][hst_pkg::FL_DONE] = 1'b1;
                    end
                    push_rsp(hst_pkg::ST_UPDATED, slot, host, 1'b1);
                end
            end
            hst_pkg::OP_LIST:
            begin
                n = 0;
                for (int i = 0; i < n_entries; i++)
                    if (!flags_q[i][hst_pkg::FL_ALIVE] && !flags_q[i][hst_pkg::FL_DONE])
                    begin
                        push_rsp(hst_pkg::ST_UPDATED, i, hosts_q[i], 1'b0);
                        n++;
                    end
                if (n == 0)
                    push_rsp(hst_pkg::ST_NONE, 0, 32'd0, 1'b1);
                else
                    awaited_rsps[awaited_rsps.size() - 1].fin = 1'b1;
            end
            default:
            begin
            end
        endcase
    endfunction

    // Driver: presents queued transactions with random gaps.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_fire)
            begin
                in_valid <= 1'b0;
                in_gap <= $urandom_range(0, StallMax);
            end
            else if (!in_valid)
            begin
                if (in_gap > 0)
                    in_gap <= in_gap - 1;
                else if (pending_reqs.size() > 0)
                begin
                    host_req_t q;
                    q = pending_reqs.pop_front();
                    operation <= q.op;
                    address <= q.addr;
                    source <= q.src;
                    probe_alive <= q.p_alive;
                    probe_dead <= q.p_dead;
                    connect_time <= q.ms;
                    in_valid <= 1'b1;
                end
            end
            if (out_fire)
                out_gap <= $urandom_range(0, StallMax);
            else if (out_gap > 0)
                out_gap <= out_gap - 1;
            out_stall <= !out_fire && (out_gap > 0);
        end
    end

    // Monitor: predicts on input acceptance and checks each result.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_fire <= in_valid && !in_stall;
            out_fire <= out_valid && !out_stall;
            quiet_cycles <= ((in_valid && !in_stall) || (out_valid && !out_stall)) ?
                            0 : quiet_cycles + 1;
            if (in_valid && !in_stall)
            begin
                host_req_t q;
                q.op = operation;
                q.addr = address;
                q.src = source;
                q.p_alive = probe_alive;
                q.p_dead = probe_dead;
                q.ms = connect_time;
                predict_table(q);
            end
            if (out_valid && !out_stall)
            begin
                host_rsp_t w;
                if (awaited_rsps.size() == 0)
                    report("unexpected result", {29'd0, status}, 32'd0);
                else
                begin
                    w = awaited_rsps.pop_front();
                    if (status !== w.st)
                        report("status", {29'd0, status}, {29'd0, w.st});
                    if (entry_index !== w.slot)
                        report("entry_index", {26'd0, entry_index}, {26'd0, w.slot});
                    if (host_index !== w.host)
                        report("host_index", host_index, w.host);
                    if (last !== w.fin)
                        report("last", {31'd0, last}, {31'd0, w.fin});
                end
            end
            if (quiet_cycles > QuietLimit)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            hst_pkg::REG_BASE:  sub_base = val;
            hst_pkg::REG_HOSTS: net_hosts = val;
            default:            live_cap = val[6:0];
        endcase
    endtask

    task automatic add_req(input logic [1:0] op, input logic [31:0] addr,
                           input logic [1:0] src, input logic pa, input logic pd,
                           input logic [15:0] ms);
        host_req_t q;
        q.op = op;
        q.addr = addr;
        q.src = src;
        q.p_alive = pa;
        q.p_dead = pd;
        q.ms = ms;
        pending_reqs.push_back(q);
    endtask

    // Random mix; addresses mostly inside the subnet and near used hosts.
    task automatic add_random(input int count, input int span);
        logic [31:0] a;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 9))
                0:       a = $urandom();
                1:       a = sub_base;
                2:       a = sub_base + net_hosts;
                default: a = sub_base + $urandom_range(1, span);
            endcase
            add_req(($urandom_range(0, 19) == 0) ? hst_pkg::OP_UNUSED :
                    2'($urandom_range(0, 2)), a,
                    2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)),
                    ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom()));
        end
    endtask

    task automatic drain;
        while (pending_reqs.size() > 0 || in_valid || awaited_rsps.size() > 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        operation = '0;
        address = '0;
        source = '0;
        probe_alive = 1'b0;
        probe_dead = 1'b0;
        connect_time = '0;
        out_stall = 1'b0;
        sub_base = 32'd0;
        net_hosts = 32'd255;
        live_cap = 7'd64;
        n_entries = 0;
        n_alive = 0;
        n_errors = 0;
        quiet_cycles = 0;
        in_gap = 0;
        out_gap = 0;
        in_fire = 1'b0;
        out_fire = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty list, outside bounds, probes, a dead probe of an alive host, op 3.
        write_reg(hst_pkg::REG_BASE, 32'hC0A8_0100);
        write_reg(hst_pkg::REG_HOSTS, 32'd256);
        write_reg(hst_pkg::REG_LIMIT, 32'd3);
        add_req(hst_pkg::OP_LIST, 32'd0, 2'd0, 1'b0, 1'b0, 16'd0);
        add_req(hst_pkg::OP_OBSERVE, 32'hC0A8_0100, 2'd0, 1'b0, 1'b0, 16'd0);
        add_req(hst_pkg::OP_OBSERVE, 32'hC0A8_0200, 2'd0, 1'b0, 1'b0, 16'd0);
        add_req(hst_pkg::OP_OBSERVE, 32'hFFFF_FFFF, 2'd3, 1'b1, 1'b1, 16'hFFFF);
        add_req(hst_pkg::OP_PROBE, 32'hC0A8_0105, 2'd1, 1'b1, 1'b0, 16'd40);
        add_req(hst_pkg::OP_OBSERVE, 32'hC0A8_0101, 2'd0, 1'b0, 1'b0, 16'd0);
        add_req(hst_pkg::OP_OBSERVE, 32'hC0A8_0101, 2'd3, 1'b0, 1'b0, 16'd0);
        add_req(hst_pkg::OP_PROBE, 32'hC0A8_0101, 2'd2, 1'b1, 1'b0, 16'd50);
        add_req(hst_pkg::OP_PROBE, 32'hC0A8_0101, 2'd1, 1'b1, 1'b1, 16'd20);
        add_req(hst_pkg::OP_PROBE, 32'hC0A8_0101, 2'd1, 1'b1, 1'b0, 16'd0);
        add_req(hst_pkg::OP_OBSERVE, 32'hC0A8_01FF, 2'd1, 1'b0, 1'b0, 16'd0);
        add_req(hst_pkg::OP_OBSERVE, 32'hC0A8_0102, 2'd2, 1'b0, 1'b0, 16'd0);
        add_req(hst_pkg::OP_OBSERVE, 32'hC0A8_0103, 2'd2, 1'b0, 1'b0, 16'd0);
        add_req(hst_pkg::OP_PROBE, 32'hC0A8_0101, 2'd0, 1'b0, 1'b1, 16'd0);
        add_req(hst_pkg::OP_LIST, 32'd0, 2'd0, 1'b0, 1'b0, 16'd0);
        add_req(hst_pkg::OP_UNUSED, 32'hFFFF_FFFF, 2'd3, 1'b1, 1'b1, 16'hFFFF);
        drain();

        // Wide subnet that reaches the top of the address space.
        write_reg(hst_pkg::REG_BASE, 32'hFFFF_FF00);
        write_reg(hst_pkg::REG_HOSTS, 32'hFFFF_FFFF);
        write_reg(hst_pkg::REG_LIMIT, 32'd0);
        add_req(hst_pkg::OP_OBSERVE, 32'hFFFF_FFFF, 2'd0, 1'b0, 1'b0, 16'd0);
        add_req(hst_pkg::OP_OBSERVE, 32'h0000_0001, 2'd0, 1'b0, 1'b0, 16'd0);
        drain();

        // Small subnet so hosts repeat; some probes land before any observe.
        write_reg(hst_pkg::REG_BASE, 32'h0A00_0000);
        write_reg(hst_pkg::REG_HOSTS, 32'd24);
        write_reg(hst_pkg::REG_LIMIT, 32'd12);
        add_random(20, 24);
        drain();

        // Large limit and many distinct hosts to grow the table.
        write_reg(hst_pkg::REG_HOSTS, 32'd200);
        write_reg(hst_pkg::REG_LIMIT, 32'd64);
        for (int i = 0; i < 5; i++)
            add_req(hst_pkg::OP_PROBE, 32'h0A00_0000 + $urandom_range(1, 150), 2'd0, 1'b0,
                    1'($urandom_range(0, 1)), 16'd0);
        for (int i = 1; i <= 50; i++)
            add_req(hst_pkg::OP_OBSERVE, 32'h0A00_0000 + 32'(i), 2'($urandom_range(0, 3)),
                    1'b0, 1'b0, 16'd0);
        add_random(6, 150);
        add_req(hst_pkg::OP_LIST, 32'd0, 2'd0, 1'b0, 1'b0, 16'd0);
        drain();

        if (n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
